FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define AST_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define AST_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/nfrf_pkg.sv
// Package with feature codes, status codes and defaults for the feature register file.
`default_nettype none

package nfrf_pkg;

    // Completion status.
    typedef logic [1:0] t_status;

    localparam t_status ST_OK             = 2'd0;
    localparam t_status ST_BAD_FIELD      = 2'd1;
    localparam t_status ST_NOT_PER_NS     = 2'd2;
    localparam t_status ST_NOT_CHANGEABLE = 2'd3;

    // Feature identifiers.
    typedef logic [7:0] t_fid;

    localparam t_fid FEAT_ARB      = 8'h01;
    localparam t_fid FEAT_POWER    = 8'h02;
    localparam t_fid FEAT_TEMP     = 8'h04;
    localparam t_fid FEAT_ERR_REC  = 8'h05;
    localparam t_fid FEAT_VWC      = 8'h06;
    localparam t_fid FEAT_QUEUES   = 8'h07;
    localparam t_fid FEAT_COALESCE = 8'h08;
    localparam t_fid FEAT_VECTOR   = 8'h09;
    localparam t_fid FEAT_ASYNC    = 8'h0B;

    // Bits that must be clear in a power management set.
    localparam logic [31:0] POWER_RSVD_MASK = 32'hFFFF_FF0F;

    // Namespace id meaning all namespaces.
    localparam logic [31:0] NSID_ALL = 32'hFFFF_FFFF;

    // Default sizes.
    localparam int DEF_IRQ_VECTORS = 16;
    localparam int DEF_QUEUE_COUNT = 16;

endpackage

`default_nettype wire

FILE: design/nvme_feature_register_file_core.sv
// Get Features / Set Features decoder with the stored feature registers.
//
// Usage: one admin command enters per item on the input channel (i_valid,
// o_stall) and exactly one completion leaves on the output channel
// (o_valid, i_stall) carrying status, completion dword 0 and the echoed tag.
// The accepting edge also reads the per-vector coalescing enable memory;
// the decide state then decides, writes back and loads the output register
// once that register is free, and o_stall stays high until then, so a new
// command is not taken before the last one is decided. The read-modify-write
// over the enable memory is the reason for this.
// The completion sits in an output register; a new command is accepted
// while it still waits. If the receiver stalls, the finished completion
// holds and the next command waits in the decide stage until the output
// register frees up.
// After reset the block runs a clearing pass over the enable memory, one
// entry per cycle, over all IRQ_VECTORS entries, with o_stall high. All scalar
// features return to their reset values at once.
`default_nettype none

module nvme_feature_register_file_core
    import nfrf_pkg::*;
#(
    parameter int IRQ_VECTORS = DEF_IRQ_VECTORS,
    parameter int QUEUE_COUNT = DEF_QUEUE_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_action,
    input  wire logic [31:0] i_dword_ten,
    input  wire logic [31:0] i_dword_eleven,
    input  wire logic [31:0] i_namespace_id,
    input  wire logic [15:0] i_command_tag,
    input  wire logic        i_reserved_clear,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_completion_value,
    output logic [15:0]      o_completion_tag
);

    localparam int          VEC_W     = (IRQ_VECTORS > 1) ? $clog2(IRQ_VECTORS) : 1;
    localparam logic [31:0] VEC_LIMIT = 32'(IRQ_VECTORS);
    localparam logic [VEC_W-1:0] VEC_LAST = VEC_W'(IRQ_VECTORS - 1);
    localparam logic [15:0] QUEUE_HALF = 16'(QUEUE_COUNT - 1);
    localparam logic [31:0] QUEUE_WORD = {QUEUE_HALF, QUEUE_HALF};

    // Controller states.
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [VEC_W-1:0] r_clr_idx;

    // Captured command.
    logic        r_action;
    logic [31:0] r_dw10;
    logic [31:0] r_dw11;
    logic [31:0] r_nsid;
    logic [15:0] r_tag;
    logic        r_rsv_ok;
    logic        r_vec_ok;
    logic [VEC_W-1:0] r_vec_idx;

    // Stored features.
    logic [2:0]  r_arb_burst;
    logic [8:0]  r_coal_thr;
    logic [7:0]  r_coal_time;
    logic [3:0]  r_wl_hint;
    logic [31:0] r_async_cfg;

    // Per-vector enable memory and its registered read data.
    logic mem_vec_en [IRQ_VECTORS];
    logic r_rd_data;

    // Output register.
    logic        r_o_valid;
    t_status     r_o_status;
    logic [31:0] r_o_value;
    logic [15:0] r_o_tag;

    logic        in_acc;
    logic        out_free;
    logic        done;
    logic        in_vec_ok;
    t_fid        fid;
    t_status     st;
    logic [31:0] val;
    logic        wr_arb, wr_coal, wr_vec, wr_power, wr_async;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign done     = (r_state == S_EXEC) && out_free;
    assign o_stall  = (r_state != S_IDLE);

    // Vector range check depends on the command: get looks at the whole dword.
    assign in_vec_ok = i_action ? ({16'd0, i_dword_eleven[15:0]} < VEC_LIMIT)
                                : (i_dword_eleven < VEC_LIMIT);

    // State sequencing.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_idx == VEC_LAST) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = S_EXEC;
            S_EXEC:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // Command capture on acceptance.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action  <= i_action;
            r_dw10    <= i_dword_ten;
            r_dw11    <= i_dword_eleven;
            r_nsid    <= i_namespace_id;
            r_tag     <= i_command_tag;
            r_rsv_ok  <= i_reserved_clear;
            r_vec_ok  <= in_vec_ok;
            r_vec_idx <= i_dword_eleven[VEC_W-1:0];
        end
    end

    // Enable memory: clearing pass after reset, else write-back from the decide stage.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem_vec_en[r_clr_idx] <= 1'b0;
        end else if (wr_vec) begin
            mem_vec_en[r_vec_idx] <= r_dw11[16];
        end
    end

    // Read issued at acceptance, only for an index inside the memory.
    always_ff @(posedge i_clk) begin
        if (in_acc && in_vec_ok) begin
            r_rd_data <= mem_vec_en[i_dword_eleven[VEC_W-1:0]];
        end
    end

    // Command decode: the first failing check decides the status.
    always_comb begin
        fid      = r_dw10[7:0];
        st       = ST_OK;
        val      = '0;
        wr_arb   = 1'b0;
        wr_coal  = 1'b0;
        wr_vec   = 1'b0;
        wr_power = 1'b0;
        wr_async = 1'b0;
        if (!r_action) begin
            priority if (!r_rsv_ok) begin
                st = ST_BAD_FIELD;
            end else if (r_dw10[31:8] != 24'd0) begin
                st = ST_BAD_FIELD;
            end else if (fid != FEAT_VECTOR && r_dw11 != 32'd0) begin
                st = ST_BAD_FIELD;
            end else begin
                unique case (fid)
                    FEAT_QUEUES:   val = QUEUE_WORD;
                    FEAT_ARB:      val = {29'd0, r_arb_burst};
                    FEAT_COALESCE: begin
                        val = {16'd0, r_coal_time, 8'(r_coal_thr - 9'd1)};
                    end
                    FEAT_VECTOR: begin
                        if (r_vec_ok) begin
                            val = r_dw11 | {15'd0, r_rd_data, 16'd0};
                        end else begin
                            st = ST_BAD_FIELD;
                        end
                    end
                    FEAT_VWC:      val = 32'd1;
                    FEAT_ERR_REC:  val = 32'd0;
                    FEAT_POWER:    val = {24'd0, r_wl_hint, 4'd0};
                    FEAT_ASYNC:    val = r_async_cfg;
                    default:       st = ST_BAD_FIELD;
                endcase
            end
        end else begin
            priority if (r_nsid != NSID_ALL && r_nsid != 32'd0) begin
                st = ST_NOT_PER_NS;
            end else if (!r_rsv_ok) begin
                st = ST_BAD_FIELD;
            end else begin
                unique case (fid)
                    FEAT_QUEUES:   val = QUEUE_WORD;
                    FEAT_ARB:      wr_arb = 1'b1;
                    FEAT_COALESCE: wr_coal = 1'b1;
                    FEAT_VECTOR: begin
                        if (r_vec_ok) begin
                            wr_vec = done;
                        end else begin
                            st = ST_BAD_FIELD;
                        end
                    end
                    FEAT_VWC: begin
                        if (r_dw11 != 32'd1) st = ST_NOT_CHANGEABLE;
                    end
                    FEAT_ERR_REC: begin
                        if (r_dw11 != 32'd0) st = ST_NOT_CHANGEABLE;
                    end
                    FEAT_POWER: begin
                        if ((r_dw11 & POWER_RSVD_MASK) != 32'd0) begin
                            st = ST_BAD_FIELD;
                        end else begin
                            wr_power = 1'b1;
                        end
                    end
                    FEAT_ASYNC:    wr_async = 1'b1;
                    default:       st = ST_BAD_FIELD;
                endcase
            end
        end
        if (st != ST_OK) begin
            val = '0;
        end
    end

    // Scalar feature registers, updated when the command completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arb_burst <= '0;
            r_coal_thr  <= 9'd1;
            r_coal_time <= '0;
            r_wl_hint   <= '0;
            r_async_cfg <= '0;
        end else if (done) begin
            if (wr_arb) r_arb_burst <= r_dw11[2:0];
            if (wr_coal) begin
                r_coal_thr  <= {1'b0, r_dw11[7:0]} + 9'd1;
                r_coal_time <= r_dw11[15:8];
            end
            if (wr_power) r_wl_hint   <= r_dw11[7:4];
            if (wr_async) r_async_cfg <= r_dw11;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (done) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_o_status <= st;
            r_o_value  <= val;
            r_o_tag    <= r_tag;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_status           = r_o_status;
    assign o_completion_value = r_o_value;
    assign o_completion_tag   = r_o_tag;

endmodule

`default_nettype wire

FILE: design/nfrf_checker.sv
// Port-level checker for the feature register file, bound into the core module.
`default_nettype none

`include "assert_macros.svh"

module nfrf_checker
    import nfrf_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_completion_value,
    input wire logic [15:0] o_completion_tag
);

    // A stalled completion keeps its contents.
    `AST_CLK(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_completion_value) && $stable(o_completion_tag), "stalled completion changed")

    // Reset empties the output register.
    `AST_CLK_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "completion shown after reset")

    // An error completion carries a zero value.
    `AST_CLK(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK |-> o_completion_value == 32'd0, "error completion with nonzero value")

    // An accepted command raises o_stall in the cycle after, blocking the next one.
    `AST_CLK(a_busy, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "command accepted while busy")

endmodule

bind nvme_feature_register_file_core nfrf_checker u_nfrf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_status           (o_status),
    .o_completion_value (o_completion_value),
    .o_completion_tag   (o_completion_tag)
);

`default_nettype wire

FILE: tb/tb_nvme_feature_register_file_core.sv
// Self-checking testbench for the NVMe Get/Set Features register file core.
`timescale 1ns / 1ps

module tb_nvme_feature_register_file_core
    import nfrf_pkg::*;
();

    // One completion as the block presents it.
    typedef struct {
        t_status     status;
        logic [31:0] value;
        logic [15:0] tag;
    } t_feature_completion;

    // Scoreboard: keeps its own copy of the stored features, predicts the
    // completion of every accepted command and checks completions in order.
    class completion_scoreboard #(int VECTORS = 16, int QUEUES = 16);
        logic [2:0]          arb_burst;
        logic [8:0]          coalesce_threshold;
        logic [7:0]          coalesce_time;
        bit                  vector_enable [VECTORS];
        logic [3:0]          workload_hint;
        logic [31:0]         async_config;
        t_feature_completion expected_completions [$];
        int                  mismatches;

        function new();
            arb_burst          = '0;
            coalesce_threshold = 9'd1;
            coalesce_time      = '0;
            foreach (vector_enable[i]) vector_enable[i] = 1'b0;
            workload_hint      = '0;
            async_config       = '0;
            mismatches         = 0;
        endfunction

        // Prints one line for the mismatch and counts it.
        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        function int pending();
            return expected_completions.size();
        endfunction

        // Works out the completion of one command and updates the stored features.
        function t_feature_completion predict_completion(logic act, logic [31:0] dw10,
                                                         logic [31:0] dw11,
                                                         logic [31:0] nsid,
                                                         logic [15:0] tag, logic rsv_ok);
            t_feature_completion c;
            t_fid                fid;
            logic [15:0]         queue_half;
            logic [15:0]         vec;
            c.status   = ST_OK;
            c.value    = '0;
            c.tag      = tag;
            fid        = dw10[7:0];
            queue_half = 16'(QUEUES - 1);
            vec        = dw11[15:0];
            if (!act) begin
                // Get: reserved fields, then the id range, then a stray dword 11.
                if (!rsv_ok || dw10 > 32'hFF || (fid != FEAT_VECTOR && dw11 != '0)) begin
                    c.status = ST_BAD_FIELD;
                end else begin
                    case (fid)
                        FEAT_QUEUES:   c.value = {queue_half, queue_half};
                        FEAT_ARB:      c.value = {29'd0, arb_burst};
                        FEAT_COALESCE: c.value = {16'd0, coalesce_time,
                                                  8'(coalesce_threshold - 9'd1)};
                        FEAT_VECTOR: begin
                            if (dw11 >= 32'(VECTORS)) begin
                                c.status = ST_BAD_FIELD;
                            end else begin
                                c.value = dw11 |
                                          (vector_enable[int'(dw11)] ? 32'h1_0000 : '0);
                            end
                        end
                        FEAT_VWC:      c.value = 32'd1;
                        FEAT_ERR_REC:  c.value = '0;
                        FEAT_POWER:    c.value = {24'd0, workload_hint, 4'd0};
                        FEAT_ASYNC:    c.value = async_config;
                        default:       c.status = ST_BAD_FIELD;
                    endcase
                end
            end else begin
                // Set: namespace first, then reserved fields, then the feature.
                if (nsid != '0 && nsid != NSID_ALL) begin
                    c.status = ST_NOT_PER_NS;
                end else if (!rsv_ok) begin
                    c.status = ST_BAD_FIELD;
                end else begin
                    case (fid)
                        FEAT_QUEUES:   c.value = {queue_half, queue_half};
                        FEAT_ARB:      arb_burst = dw11[2:0];
                        FEAT_COALESCE: begin
                            coalesce_threshold = {1'b0, dw11[7:0]} + 9'd1;
                            coalesce_time      = dw11[15:8];
                        end
                        FEAT_VECTOR: begin
                            if (vec >= 16'(VECTORS)) begin
                                c.status = ST_BAD_FIELD;
                            end else begin
                                vector_enable[int'(vec)] = dw11[16];
                            end
                        end
                        FEAT_VWC:      if (dw11 != 32'd1) c.status = ST_NOT_CHANGEABLE;
                        FEAT_ERR_REC:  if (dw11 != '0) c.status = ST_NOT_CHANGEABLE;
                        FEAT_POWER: begin
                            if ((dw11 & POWER_RSVD_MASK) != '0) begin
                                c.status = ST_BAD_FIELD;
                            end else begin
                                workload_hint = dw11[7:4];
                            end
                        end
                        FEAT_ASYNC:    async_config = dw11;
                        default:       c.status = ST_BAD_FIELD;
                    endcase
                end
            end
            if (c.status != ST_OK) c.value = '0;
            return c;
        endfunction

        task note_command(logic act, logic [31:0] dw10, logic [31:0] dw11,
                          logic [31:0] nsid, logic [15:0] tag, logic rsv_ok);
            expected_completions.push_back(
                predict_completion(act, dw10, dw11, nsid, tag, rsv_ok));
        endtask

        task check_completion(t_status status, logic [31:0] value, logic [15:0] tag);
            t_feature_completion e;
            if (expected_completions.size() == 0) begin
                report_mismatch($sformatf("completion tag %h with no command pending", tag));
            end else begin
                e = expected_completions.pop_front();
                if (status !== e.status)
                    report_mismatch($sformatf("tag %h status %0d, expected %0d",
                                              e.tag, status, e.status));
                if (value !== e.value)
                    report_mismatch($sformatf("tag %h value %h, expected %h",
                                              e.tag, value, e.value));
                if (tag !== e.tag)
                    report_mismatch($sformatf("tag %h, expected %h", tag, e.tag));
            end
        endtask
    endclass

    localparam int IRQ_VECTORS     = DEF_IRQ_VECTORS;
    localparam int QUEUE_COUNT     = DEF_QUEUE_COUNT;
    localparam int CLK_PERIOD      = 8;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [31:0] i_dword_ten;
    logic [31:0] i_dword_eleven;
    logic [31:0] i_namespace_id;
    logic [15:0] i_command_tag;
    logic        i_reserved_clear;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [31:0] o_completion_value;
    logic [15:0] o_completion_tag;

    bit hold_off_request;

    completion_scoreboard #(IRQ_VECTORS, QUEUE_COUNT) sb;

    nvme_feature_register_file_core #(
        .IRQ_VECTORS(IRQ_VECTORS),
        .QUEUE_COUNT(QUEUE_COUNT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_dword_ten        (i_dword_ten),
        .i_dword_eleven     (i_dword_eleven),
        .i_namespace_id     (i_namespace_id),
        .i_command_tag      (i_command_tag),
        .i_reserved_clear   (i_reserved_clear),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_completion_value (o_completion_value),
        .o_completion_tag   (o_completion_tag)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // Offers one command and returns at the edge that accepts it.
    task automatic send_command(logic act, logic [31:0] dw10, logic [31:0] dw11,
                                logic [31:0] nsid, logic [15:0] tag, logic rsv_ok);
        i_valid          <= 1'b1;
        i_action         <= act;
        i_dword_ten      <= dw10;
        i_dword_eleven   <= dw11;
        i_namespace_id   <= nsid;
        i_command_tag    <= tag;
        i_reserved_clear <= rsv_ok;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_input(int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Mostly well-formed commands on known features with random content.
    task automatic send_random_command();
        logic        act;
        logic [31:0] dw10;
        logic [31:0] dw11;
        logic [31:0] nsid;
        logic        rsv_ok;
        t_fid        fid;
        t_fid        known [9];
        int          r;
        known = '{FEAT_ARB, FEAT_POWER, FEAT_TEMP, FEAT_ERR_REC, FEAT_VWC,
                  FEAT_QUEUES, FEAT_COALESCE, FEAT_VECTOR, FEAT_ASYNC};
        act = 1'($urandom_range(0, 1));
        fid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : known[$urandom_range(0, 8)];
        dw10 = ($urandom_range(0, 99) < 85) ? {24'd0, fid} : {24'($urandom), fid};
        r = $urandom_range(0, 99);
        if (!act) begin
            if (fid == FEAT_VECTOR) begin
                if (r < 75)      dw11 = $urandom_range(0, IRQ_VECTORS - 1);
                else if (r < 90) dw11 = $urandom_range(IRQ_VECTORS, IRQ_VECTORS + 24);
                else             dw11 = $urandom;
            end else begin
                dw11 = (r < 85) ? '0 : $urandom;
            end
        end else begin
            case (fid)
                FEAT_VECTOR:  dw11 = (r < 80) ? {15'($urandom), 1'($urandom),
                                                 16'($urandom_range(0, IRQ_VECTORS - 1))}
                                              : $urandom;
                FEAT_VWC:     dw11 = (r < 70) ? 32'd1 : $urandom;
                FEAT_ERR_REC: dw11 = (r < 70) ? 32'd0 : $urandom;
                FEAT_POWER:   dw11 = (r < 75) ? {24'd0, 4'($urandom), 4'd0} : $urandom;
                default:      dw11 = $urandom;
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 45)      nsid = '0;
        else if (r < 90) nsid = NSID_ALL;
        else             nsid = $urandom;
        rsv_ok = ($urandom_range(0, 99) < 92);
        send_command(act, dw10, dw11, nsid, 16'($urandom), rsv_ok);
    endtask

    // Checks completions first, then notes the command taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_completion(o_status, o_completion_value, o_completion_tag);
            if (i_valid && !o_stall)
                sb.note_command(i_action, i_dword_ten, i_dword_eleven, i_namespace_id,
                                i_command_tag, i_reserved_clear);
        end
    end

    // Receiver: random stalls, free stretches, and one long hold-off on request.
    initial begin
        int hold_left;
        int stall_left;
        int free_left;
        hold_left  = 0;
        stall_left = 0;
        free_left  = 0;
        i_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_left        = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (free_left > 0) begin
                i_stall <= 1'b0;
                free_left--;
            end else begin
                i_stall    <= 1'b0;
                stall_left = pick_gap();
                free_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 5);
            end
        end
    end

    // Watchdog: ends the run when no command is accepted and no completion taken for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("tb_nvme_feature_register_file_core: FAIL");
        $finish;
    end

    // Main sequence: reset, directed commands, random commands, drain.
    initial begin
        bit burst_mode;
        sb               = new();
        hold_off_request = 1'b0;
        burst_mode       = 1'b0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_action         = 1'b0;
        i_dword_ten      = '0;
        i_dword_eleven   = '0;
        i_namespace_id   = '0;
        i_command_tag    = '0;
        i_reserved_clear = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reads of every supported feature at reset values, and the get-side errors.
        send_command(1'b0, {24'd0, FEAT_ARB}, '0, '0, 16'h0000, 1'b1);
        send_command(1'b0, {24'd0, FEAT_COALESCE}, '0, '0, 16'hFFFF, 1'b1);
        idle_input(pick_gap());
        send_command(1'b0, {24'd0, FEAT_QUEUES}, '0, NSID_ALL, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_VWC}, '0, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_ERR_REC}, '0, '0, 16'($urandom), 1'b1);
        idle_input(pick_gap());
        send_command(1'b0, {24'd0, FEAT_POWER}, '0, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_ASYNC}, '0, '0, 16'($urandom), 1'b1);
        send_command(1'b0, 32'h0000_00FF, '0, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'h000001, FEAT_QUEUES}, '0, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_ARB}, '0, '0, 16'($urandom), 1'b0);
        send_command(1'b0, {24'd0, FEAT_ARB}, 32'd1, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_VECTOR}, IRQ_VECTORS - 1, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_VECTOR}, IRQ_VECTORS, '0, 16'($urandom), 1'b1);

        // Writes at the extremes, the set-side errors, then read-back.
        send_command(1'b1, {24'd0, FEAT_ARB}, 32'hFFFF_FFFF, NSID_ALL, 16'($urandom), 1'b1);
        send_command(1'b1, {24'd0, FEAT_COALESCE}, 32'h0000_FFFF, '0, 16'($urandom), 1'b1);
        idle_input(pick_gap());
        send_command(1'b1, {24'd0, FEAT_VECTOR}, 32'h0001_0000 | (IRQ_VECTORS - 1), '0,
                     16'($urandom), 1'b1);
        send_command(1'b1, {24'd0, FEAT_VECTOR}, IRQ_VECTORS, '0, 16'($urandom), 1'b1);
        send_command(1'b1, {24'd0, FEAT_VWC}, '0, '0, 16'($urandom), 1'b1);
        send_command(1'b1, {24'd0, FEAT_ERR_REC}, 32'd1, '0, 16'($urandom), 1'b1);
        send_command(1'b1, {24'd0, FEAT_POWER}, 32'h0000_00F0, '0, 16'($urandom), 1'b1);
        send_command(1'b1, {24'd0, FEAT_POWER}, 32'h0000_0001, '0, 16'($urandom), 1'b1);
        send_command(1'b1, {24'hFFFFFF, FEAT_ASYNC}, 32'hFFFF_FFFF, '0,
                     16'($urandom), 1'b1);
        send_command(1'b1, {24'd0, FEAT_QUEUES}, '0, 32'd5, 16'($urandom), 1'b1);
        send_command(1'b1, {24'd0, FEAT_ARB}, '0, '0, 16'($urandom), 1'b0);
        send_command(1'b1, {24'd0, FEAT_TEMP}, '0, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_COALESCE}, '0, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_VECTOR}, IRQ_VECTORS - 1, '0, 16'($urandom), 1'b1);
        send_command(1'b0, {24'd0, FEAT_ASYNC}, '0, '0, 16'($urandom), 1'b1);
        idle_input(pick_gap());

        // Random commands; one stretch is offered back to back under a long hold-off.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (n == 400) hold_off_request = 1'b1;
            send_random_command();
            if (!burst_mode && !(n >= 400 && n < 440)) idle_input(pick_gap());
        end
        i_valid <= 1'b0;

        // Drain, then allow the pipeline latency before deciding.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_nvme_feature_register_file_core: PASS");
        end else begin
            $display("tb_nvme_feature_register_file_core: FAIL");
        end
        $finish;
    end

endmodule
